// File: rtl/core/njd_pkg.sv
// ============================================================================
// njd_pkg
// Shared types, constants and helpers for the job dispatcher.
// ============================================================================
package njd_pkg;

	// Ready table geometry
	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	// Input kinds
	localparam logic FUNC_TICK    = 1'b0;
	localparam logic FUNC_ARRIVAL = 1'b1;

	// Event codes
	localparam logic [2:0] EV_ACCEPTED   = 3'd0;
	localparam logic [2:0] EV_DROPPED    = 3'd1;
	localparam logic [2:0] EV_DISPATCHED = 3'd2;
	localparam logic [2:0] EV_COMPLETED  = 3'd3;
	localparam logic [2:0] EV_IDLE       = 3'd4;
	localparam logic [2:0] EV_BUSY       = 3'd5;

	// Policy modes (unused code falls back to id order)
	localparam logic [1:0] MODE_ID    = 2'd0;
	localparam logic [1:0] MODE_BURST = 2'd1;
	localparam logic [1:0] MODE_PRIO  = 2'd2;

	// Register map
	localparam logic REG_POLICY = 1'b0;

	// One ready table entry
	typedef struct packed {
		logic [7:0]  id;
		logic [7:0]  burst;
		logic [7:0]  prio;
		logic [31:0] arrival;
	} entry_t;

	// Incoming item
	typedef struct packed {
		logic       func;
		logic [7:0] job_id;
		logic [7:0] job_burst;
		logic [7:0] job_priority;
	} item_t;

	// Result item
	typedef struct packed {
		logic [2:0]  event_res;
		logic [7:0]  out_id;
		logic [31:0] turnaround;
		logic [31:0] waiting;
		logic [15:0] dispatched_count;
		logic [15:0] idle_ticks;
		logic [4:0]  queue_length;
	} result_t;

	// Table memory ports
	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		entry_t           data;
	} tbl_wr_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
	} tbl_rd_t;

	// Ordering key of an entry under the current policy
	function automatic logic [7:0] key_of(entry_t e, logic [1:0] mode);
		logic [7:0] k;
		case (mode)
			MODE_BURST: k = e.burst;
			MODE_PRIO:  k = e.prio;
			default:    k = e.id;
		endcase
		return k;
	endfunction

	// Fill count reported in five bits
	function automatic logic [4:0] qlen_of(logic [CNT_W-1:0] c);
		logic [CNT_W+4:0] w;
		w = (CNT_W + 5)'(c);
		return w[4:0];
	endfunction

endpackage

// File: rtl/core/njd_table_ram.sv
// ============================================================================
// njd_table_ram
// Ready table storage: one write port, one read port, registered read data.
// ============================================================================
module njd_table_ram (
	input  logic            clk,
	input  njd_pkg::tbl_wr_t wr,
	input  njd_pkg::tbl_rd_t rd,
	output njd_pkg::entry_t  rd_data
);
	import njd_pkg::*;

	entry_t mem [TABLE_DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			rd_data <= mem[rd.addr];
		end
	end

endmodule

// File: rtl/core/njd_sched.sv
// ============================================================================
// njd_sched
// Dispatch sequencer: run state, tick clock, table scan and gap closing.
// ============================================================================
module njd_sched (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [1:0]        mode,
	input  logic              item_valid,
	output logic              item_ready,
	input  njd_pkg::item_t    item,
	output logic              res_valid,
	input  logic              res_take,
	output njd_pkg::result_t  res
);
	import njd_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_SCAN  = 6'b000010,
		ST_DISP  = 6'b000100,
		ST_SHIFT = 6'b001000,
		ST_FIN   = 6'b010000,
		ST_EMIT  = 6'b100000
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] count_q;
	logic [31:0]      tick_q;
	logic             running_q;
	logic [7:0]       remaining_q;
	logic [7:0]       run_id_q;
	logic [7:0]       run_burst_q;
	logic [31:0]      run_arrival_q;
	logic [15:0]      dispatch_q;
	logic [15:0]      idle_q;

	logic [2:0]       res_ev_q;
	logic [7:0]       res_id_q;
	logic [31:0]      res_tat_q;
	logic [IDX_W-1:0] rd_idx_q;
	logic [IDX_W-1:0] best_idx_q;
	logic [7:0]       best_key_q;
	entry_t           best_ent_q;
	logic [IDX_W-1:0] sh_idx_q;

	tbl_wr_t          tbl_wr;
	tbl_rd_t          tbl_rd;
	entry_t           tbl_rdata;

	logic             accept;
	logic             is_full;
	logic [7:0]       cur_key;
	logic             scan_take;
	logic             scan_last;
	logic             disp_shift;
	logic             shift_more;

	njd_table_ram u_table (
		.clk     (clk),
		.wr      (tbl_wr),
		.rd      (tbl_rd),
		.rd_data (tbl_rdata)
	);

	assign item_ready = (state_q == ST_IDLE);
	assign accept     = item_valid && item_ready;
	assign is_full    = (count_q >= CNT_W'(TABLE_DEPTH));

	// Scan compare: strict less keeps the earliest entry on ties
	assign cur_key    = key_of(tbl_rdata, mode);
	assign scan_take  = (rd_idx_q == '0) || (cur_key < best_key_q);
	assign scan_last  = ((CNT_W'(rd_idx_q) + CNT_W'(1)) >= count_q);
	// count_q is still the old count in DISP and the new count in SHIFT
	assign disp_shift = ((CNT_W'(best_idx_q) + CNT_W'(1)) < count_q);
	assign shift_more = (CNT_W'(sh_idx_q) < count_q);

	// Table port requests; reads and writes never target the same entry
	always_comb begin
		tbl_wr = '0;
		tbl_rd = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept && item.func == FUNC_ARRIVAL && !is_full) begin
					tbl_wr.en         = 1'b1;
					tbl_wr.addr       = count_q[IDX_W-1:0];
					tbl_wr.data.id    = item.job_id;
					tbl_wr.data.burst = item.job_burst;
					tbl_wr.data.prio  = item.job_priority;
					tbl_wr.data.arrival = tick_q;
				end
				if (accept && item.func == FUNC_TICK && !running_q && count_q != '0) begin
					tbl_rd.en   = 1'b1;
					tbl_rd.addr = '0;
				end
			end
			ST_SCAN: begin
				if (!scan_last) begin
					tbl_rd.en   = 1'b1;
					tbl_rd.addr = rd_idx_q + IDX_W'(1);
				end
			end
			ST_DISP: begin
				if (disp_shift) begin
					tbl_rd.en   = 1'b1;
					tbl_rd.addr = best_idx_q + IDX_W'(1);
				end
			end
			ST_SHIFT: begin
				tbl_wr.en   = 1'b1;
				tbl_wr.addr = sh_idx_q - IDX_W'(1);
				tbl_wr.data = tbl_rdata;
				if (shift_more) begin
					tbl_rd.en   = 1'b1;
					tbl_rd.addr = sh_idx_q + IDX_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// Control and job state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			count_q       <= '0;
			tick_q        <= '0;
			running_q     <= 1'b0;
			remaining_q   <= '0;
			run_id_q      <= '0;
			run_burst_q   <= '0;
			run_arrival_q <= '0;
			dispatch_q    <= '0;
			idle_q        <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (item.func == FUNC_ARRIVAL) begin
							if (!is_full) begin
								count_q <= count_q + CNT_W'(1);
							end
							state_q <= ST_EMIT;
						end else begin
							tick_q <= tick_q + 32'd1;
							if (running_q) begin
								if (remaining_q <= 8'd1) begin
									running_q   <= 1'b0;
									remaining_q <= '0;
									state_q     <= ST_FIN;
								end else begin
									remaining_q <= remaining_q - 8'd1;
									state_q     <= ST_EMIT;
								end
							end else if (count_q == '0) begin
								idle_q  <= idle_q + 16'd1;
								state_q <= ST_EMIT;
							end else begin
								state_q <= ST_SCAN;
							end
						end
					end
				end
				ST_SCAN: begin
					if (scan_last) begin
						state_q <= ST_DISP;
					end
				end
				ST_DISP: begin
					run_id_q      <= best_ent_q.id;
					run_burst_q   <= best_ent_q.burst;
					remaining_q   <= best_ent_q.burst;
					run_arrival_q <= best_ent_q.arrival;
					running_q     <= 1'b1;
					count_q       <= count_q - CNT_W'(1);
					dispatch_q    <= dispatch_q + 16'd1;
					state_q       <= disp_shift ? ST_SHIFT : ST_EMIT;
				end
				ST_SHIFT: begin
					if (!shift_more) begin
						state_q <= ST_EMIT;
					end
				end
				ST_FIN: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Scan pointers, best candidate and pending result
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				rd_idx_q  <= '0;
				res_tat_q <= '0;
				if (item.func == FUNC_ARRIVAL) begin
					res_ev_q <= is_full ? EV_DROPPED : EV_ACCEPTED;
					res_id_q <= item.job_id;
				end else if (running_q) begin
					res_ev_q <= (remaining_q <= 8'd1) ? EV_COMPLETED : EV_BUSY;
					res_id_q <= run_id_q;
				end else begin
					res_ev_q <= EV_IDLE;
					res_id_q <= '0;
				end
			end
			ST_SCAN: begin
				if (scan_take) begin
					best_idx_q <= rd_idx_q;
					best_key_q <= cur_key;
					best_ent_q <= tbl_rdata;
				end
				if (!scan_last) begin
					rd_idx_q <= rd_idx_q + IDX_W'(1);
				end
			end
			ST_DISP: begin
				res_ev_q  <= EV_DISPATCHED;
				res_id_q  <= best_ent_q.id;
				res_tat_q <= '0;
				sh_idx_q  <= best_idx_q + IDX_W'(1);
			end
			ST_SHIFT: begin
				if (shift_more) begin
					sh_idx_q <= sh_idx_q + IDX_W'(1);
				end
			end
			ST_FIN: begin
				res_tat_q <= tick_q - run_arrival_q;
			end
			default: begin
			end
		endcase
	end

	// Result assembly
	assign res_valid = (state_q == ST_EMIT);

	always_comb begin
		res.event_res        = res_ev_q;
		res.out_id           = res_id_q;
		res.turnaround       = res_tat_q;
		res.waiting          = (res_ev_q == EV_COMPLETED) ?
		                       (res_tat_q - 32'(run_burst_q)) : '0;
		res.dispatched_count = dispatch_q;
		res.idle_ticks       = idle_q;
		res.queue_length     = qlen_of(count_q);
	end

endmodule

// File: rtl/core/nonpreemptive_job_dispatcher_top.sv
// ============================================================================
// nonpreemptive_job_dispatcher_top
// Non-preemptive job dispatcher with a sixteen-entry ready table.
// ============================================================================
// Usage:
//   Input stream (s_*): s_tuser is the kind (0 tick, 1 arrival), s_tdata
//   carries the arriving job's id, burst and priority. Every input
//   transaction yields exactly one output transaction on m_*; m_tuser is the
//   event code, m_tdata the job id, timing figures and counters.
//   The policy register (smallest id, burst or priority value) is written
//   through the APB port at address 0; the user must write it only while
//   the block is idle, which the block itself does not enforce. Arrivals,
//   idle and busy ticks go from the EMIT state to the output register; a
//   completion passes the FIN state first. A dispatching tick scans the
//   table through the single memory read port, one entry per cycle, then
//   closes the gap left by the chosen entry one entry per cycle.
//   One item is in work at a time; s_tready is high while the sequencer waits
//   for work, and a new item is taken while an earlier result still sits in
//   the output register. A stalled receiver holds the result there and the
//   next result waits in the sequencer until it is taken.
//   Reset empties the table and clears the clock, counters and policy; no
//   clearing pass is needed.
// ============================================================================
module nonpreemptive_job_dispatcher_top (
	input  logic         clk,
	input  logic         arst_n,
	// Input stream
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [23:0]  s_tdata,   // job_id[7:0], job_burst[15:8], job_priority[23:16]
	input  logic [0:0]   s_tuser,   // func[0]
	// Output stream
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [111:0] m_tdata,   // out_id[7:0], turnaround[39:8], waiting[71:40],
	                                // dispatched_count[87:72], idle_ticks[103:88],
	                                // queue_length[108:104], zero[111:109]
	output logic [2:0]   m_tuser,   // event_res[2:0]
	// Configuration
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	import njd_pkg::*;

	logic [1:0] mode_q;
	item_t      item;
	result_t    res;
	logic       res_valid;
	logic       res_take;
	logic       m_valid_q;
	result_t    m_res_q;

	// Configuration register
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_ID;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_POLICY) begin
			mode_q <= pwdata[1:0];
		end
	end

	assign prdata = (paddr[2] == REG_POLICY) ? {30'd0, mode_q} : '0;

	// Input unpacking
	always_comb begin
		item.func         = s_tuser[0];
		item.job_id       = s_tdata[7:0];
		item.job_burst    = s_tdata[15:8];
		item.job_priority = s_tdata[23:16];
	end

	njd_sched u_sched (
		.clk        (clk),
		.arst_n     (arst_n),
		.mode       (mode_q),
		.item_valid (s_tvalid),
		.item_ready (s_tready),
		.item       (item),
		.res_valid  (res_valid),
		.res_take   (res_take),
		.res        (res)
	);

	// Output register
	assign res_take = res_valid && (!m_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_take) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			m_res_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_res_q.event_res;
	assign m_tdata  = {3'd0, m_res_q.queue_length, m_res_q.idle_ticks,
	                   m_res_q.dispatched_count, m_res_q.waiting,
	                   m_res_q.turnaround, m_res_q.out_id};

	// Checks
	a_busy_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && res_valid))
		else $error("sequencer offers a result while taking input");

	a_tat_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && m_res_q.event_res != EV_COMPLETED) |->
		(m_res_q.turnaround == '0 && m_res_q.waiting == '0))
		else $error("timing figures on a non-completion event");

	a_idle_no_id: assert property (@(posedge clk) disable iff (!arst_n)
		(res_take && res.event_res == EV_IDLE) |-> (res.out_id == '0))
		else $error("idle tick carries a job id");

	a_take_loads: assert property (@(posedge clk) disable iff (!arst_n)
		res_take |=> (m_valid_q && m_res_q.event_res == $past(res.event_res)))
		else $error("output register missed a result");

endmodule
